### hw/rtl/urfp_pkg.sv
// Shared types, codes and constants of the request frame parser.
`timescale 1ns / 1ps
`default_nettype none
package urfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 4096;
  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned CNT_FULL_W  = $clog2(MAX_PAYLOAD) + 1;
  localparam int unsigned CNT_W       = (CNT_FULL_W > 3) ? CNT_FULL_W : 3;
  localparam int unsigned IDX_W       = 12;

  localparam logic [31:0] START_WORD = 32'h3141_4655;
  localparam logic [31:0] GUARD_WORD = 32'h4853_5246;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

  localparam logic [31:0] CMD_WIPE  = 32'd2;
  localparam logic [31:0] CMD_WRITE = 32'd3;
  localparam logic [31:0] CMD_LAST  = 32'd4;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_GUARD   = 3'd1,
    PH_CMD     = 3'd2,
    PH_ADDR    = 3'd3,
    PH_LEN     = 3'd4,
    PH_HCHK    = 3'd5,
    PH_PCHK    = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_MATCH   = 2'd2,
    EV_REJECT  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_CMD = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_CHKSUM  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [1:0]       status_code;
    logic [31:0]      request_command;
    logic [31:0]      request_address;
    logic [31:0]      request_length;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/uart_request_frame_parser.sv
// Top level of the request frame parser: one received byte per input handshake.
// A result appears on out_valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle; in_ready drops only while a result waits
// in the single result register and out_ready is low.
// Reset (rst_n low, synchronous): parser returns to start word hunt with all
// header words cleared, and the result register is emptied.
`timescale 1ns / 1ps
`default_nettype none
module uart_request_frame_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [7:0]                 in_rx_byte,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [1:0]                 out_event_kind,
  output      logic [1:0]                 out_status_code,
  output      logic [31:0]                out_request_command,
  output      logic [31:0]                out_request_address,
  output      logic [31:0]                out_request_length,
  output      logic [7:0]                 out_payload_byte,
  output      logic [urfp_pkg::IDX_W-1:0] out_payload_index
);
  import urfp_pkg::*;

  logic    byte_fire;
  logic    res_vld;
  logic    can_take;
  result_t res;
  result_t out_res;

  assign in_ready  = can_take;
  assign byte_fire = in_valid && can_take;

  urfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .rx_byte   (in_rx_byte),
    .res_vld   (res_vld),
    .res       (res)
  );

  urfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (byte_fire && res_vld),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_take  (can_take),
    .out_res   (out_res)
  );

  assign out_event_kind      = out_res.event_kind;
  assign out_status_code     = out_res.status_code;
  assign out_request_command = out_res.request_command;
  assign out_request_address = out_res.request_address;
  assign out_request_length  = out_res.request_length;
  assign out_payload_byte    = out_res.payload_byte;
  assign out_payload_index   = out_res.payload_index;

endmodule
`default_nettype wire

### hw/rtl/urfp_core.sv
// Parse state machine: start word hunt, header words, payload sum.
`timescale 1ns / 1ps
`default_nettype none
module urfp_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_fire,
  input  wire logic [7:0]       rx_byte,
  output      logic             res_vld,
  output      urfp_pkg::result_t res
);
  import urfp_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [31:0]      win_r, win_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      asm_r, asm_nxt;
  logic [31:0]      cmd_r, cmd_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      exp_r, exp_nxt;
  logic [31:0]      sum_r, sum_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      asm_new;
  logic [31:0]      sum_new;
  logic [31:0]      want;
  status_t          hdr_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      win_r   <= '0;
      cnt_r   <= '0;
      asm_r   <= '0;
      cmd_r   <= '0;
      addr_r  <= '0;
      len_r   <= '0;
      exp_r   <= '0;
      sum_r   <= '0;
    end else if (byte_fire) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      cnt_r   <= cnt_nxt;
      asm_r   <= asm_nxt;
      cmd_r   <= cmd_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      exp_r   <= exp_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_comb begin
    cnt_inc = cnt_r + CNT_W'(1);
    asm_new = {rx_byte, asm_r[31:8]};
    sum_new = {sum_r[26:0], sum_r[31:27]} ^ {24'd0, rx_byte};
    want    = ~(GUARD_WORD ^ cmd_r ^ addr_r ^ len_r);

    if (asm_new != want) begin
      hdr_status = ST_CHKSUM;
    end else if (cmd_r > CMD_LAST) begin
      hdr_status = ST_BAD_CMD;
    end else if (cmd_r == CMD_WIPE && len_r == '0) begin
      hdr_status = ST_BAD_LEN;
    end else if (cmd_r == CMD_WRITE &&
                 (len_r == '0 || len_r > 32'(MAX_PAYLOAD))) begin
      hdr_status = ST_BAD_LEN;
    end else begin
      hdr_status = ST_OK;
    end

    phase_nxt = phase_r;
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    asm_nxt   = asm_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    exp_nxt   = exp_r;
    sum_nxt   = sum_r;

    res_vld               = 1'b0;
    res.event_kind        = EV_HEADER;
    res.status_code       = ST_OK;
    res.request_command   = cmd_r;
    res.request_address   = addr_r;
    res.request_length    = len_r;
    res.payload_byte      = '0;
    res.payload_index     = '0;

    case (phase_r)
      PH_HUNT: begin
        win_nxt = {rx_byte, win_r[31:8]};
        if (win_nxt == START_WORD) begin
          phase_nxt = PH_GUARD;
          cnt_nxt   = '0;
          asm_nxt   = '0;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt           = sum_new;
        cnt_nxt           = cnt_inc;
        res_vld           = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = IDX_W'(cnt_r);
        if (32'(cnt_inc) >= len_r) begin
          res.event_kind  = (sum_new == exp_r) ? EV_MATCH : EV_REJECT;
          res.status_code = (sum_new == exp_r) ? ST_OK : ST_CHKSUM;
          phase_nxt = PH_HUNT;
          win_nxt   = '0;
          cnt_nxt   = '0;
          asm_nxt   = '0;
        end else begin
          res.event_kind  = EV_PAYLOAD;
        end
      end
      default: begin
        asm_nxt = asm_new;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= CNT_W'(WORD_BYTES)) begin
          cnt_nxt = '0;
          asm_nxt = '0;
          case (phase_r)
            PH_GUARD: begin
              if (asm_new != GUARD_WORD) begin
                cmd_nxt             = ALL_ONES;
                addr_nxt            = '0;
                len_nxt             = '0;
                res_vld             = 1'b1;
                res.event_kind      = EV_REJECT;
                res.status_code     = ST_CHKSUM;
                res.request_command = ALL_ONES;
                res.request_address = '0;
                res.request_length  = '0;
                phase_nxt           = PH_HUNT;
                win_nxt             = '0;
              end else begin
                phase_nxt = PH_CMD;
              end
            end
            PH_CMD: begin
              cmd_nxt   = asm_new;
              phase_nxt = PH_ADDR;
            end
            PH_ADDR: begin
              addr_nxt  = asm_new;
              phase_nxt = PH_LEN;
            end
            PH_LEN: begin
              len_nxt   = asm_new;
              phase_nxt = PH_HCHK;
            end
            PH_HCHK: begin
              res_vld = 1'b1;
              if (hdr_status != ST_OK) begin
                res.event_kind  = EV_REJECT;
                res.status_code = hdr_status;
                phase_nxt       = PH_HUNT;
                win_nxt         = '0;
              end else if (cmd_r == CMD_WRITE) begin
                phase_nxt = PH_PCHK;
              end else begin
                phase_nxt = PH_HUNT;
                win_nxt   = '0;
              end
            end
            PH_PCHK: begin
              exp_nxt   = asm_new;
              sum_nxt   = '0;
              phase_nxt = PH_PAYLOAD;
            end
            default: begin
              phase_nxt = PH_HUNT;
              win_nxt   = '0;
            end
          endcase
        end
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/urfp_out_reg.sv
// Result register with valid/ready handshake towards the consumer.
`timescale 1ns / 1ps
`default_nettype none
module urfp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire urfp_pkg::result_t res,
  input  wire logic              out_ready,
  output      logic              out_valid,
  output      logic              can_take,
  output      urfp_pkg::result_t out_res
);
  import urfp_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign can_take  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/urfp_chk.sv
// Port-level checker for the request frame parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module urfp_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [1:0]                 out_event_kind,
  input wire logic [1:0]                 out_status_code,
  input wire logic [7:0]                 out_payload_byte,
  input wire logic [urfp_pkg::IDX_W-1:0] out_payload_index
);
  import urfp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_PAYLOAD || out_event_kind == EV_MATCH)
      |-> out_status_code == ST_OK)
    else $error("payload or match result with non-ok status");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_HEADER
      |-> out_status_code == ST_OK && out_payload_byte == '0 &&
          out_payload_index == '0)
    else $error("header result carries payload fields or error status");

  a_reject_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_REJECT |-> out_status_code != ST_OK)
    else $error("rejection without an error status");

endmodule

bind uart_request_frame_parser urfp_chk u_urfp_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_event_kind    (out_event_kind),
  .out_status_code   (out_status_code),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index)
);
`default_nettype wire
